// ===== src/pcor_pkg.sv =====
// Shared constants and types for the phase current offset reconstruction block.
package pcor_pkg;

  localparam int RAW_W  = 16;  // ADC sample width
  localparam int CUR_W  = 18;  // signed current width
  localparam int TOPO_W = 2;   // topology register width

  localparam logic [RAW_W-1:0] MID_CODE   = 16'd32768;
  localparam logic [RAW_W-1:0] MIN_OFFSET = 16'd8000;

  // topology register codes
  localparam logic [TOPO_W-1:0] TOPO_THREE = 2'd0;
  localparam logic [TOPO_W-1:0] TOPO_TWO   = 2'd1;

  // input item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_START  = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_W    = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

endpackage

// ===== src/pcor_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pcor_div #(
  parameter int DIVD_W = 32,
  parameter int QUO_W  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVD_W-1:0]         dividend_i,
  input  logic [DIVD_W-QUO_W-1:0]   divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [QUO_W-1:0]          quotient_o
);

  // Caller guarantees quotient < 2**QUO_W, so the upper part of the
  // dividend is already below the divisor.
  localparam int DW = DIVD_W - QUO_W;
  localparam int CW = $clog2(QUO_W + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DW:0] shifted;
  logic [DW:0] diff;
  logic        take;

  assign shifted = {rem_q, quo_q[QUO_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[DIVD_W-1:QUO_W];
      quo_d  = dividend_i[QUO_W-1:0];
      dvs_d  = divisor_i;
      cnt_d  = CW'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[DW-1:0] : shifted[DW-1:0];
      quo_d = {quo_q[QUO_W-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/phase_current_offset_reconstruct.sv =====
// Top level: phase current offset calibration and current reconstruction.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | sink      | in_valid_i / in_ready_o| kind_i, raw_u_i, raw_v_i, raw_w_i
//  out     | source    | out_valid_o/out_ready_i| current_{u,v,w}_o, is_calibrated_o,
//          |           |                        | in_calibration_o
//  cfg     | sink      | cfg_we_i (no wait)     | cfg_wdata_i -> topology
//
// Sequence: a start command gives no result. A calibration sample goes
//   straight to the output, the last one first averages each phase's sum
//   through the divider. A reconstruction divides once per phase with three
//   or two shunts (with two, one more state derives w) and skips the divider
//   with a single shunt; the shared divider gives one quotient bit per cycle,
//   QUO_W = 16 at the default Q_SCALE.
// Reset: all control state clears at once; no clearing pass.
// Stalls: in_ready_o is high only in idle; a finished result waits in the
//   output register while the next transaction is accepted.
module phase_current_offset_reconstruct #(
  parameter int CAL_SAMPLES = 512,
  parameter int Q_SCALE     = 32768
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [pcor_pkg::RAW_W-1:0]        raw_u_i,
  input  logic [pcor_pkg::RAW_W-1:0]        raw_v_i,
  input  logic [pcor_pkg::RAW_W-1:0]        raw_w_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pcor_pkg::CUR_W-1:0] current_u_o,
  output logic signed [pcor_pkg::CUR_W-1:0] current_v_o,
  output logic signed [pcor_pkg::CUR_W-1:0] current_w_o,
  output logic                              is_calibrated_o,
  output logic                              in_calibration_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [pcor_pkg::TOPO_W-1:0]       cfg_wdata_i
);

  import pcor_pkg::*;

  // Widths derived from the parameters
  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W  = RAW_W + $clog2(CAL_SAMPLES);
  localparam int QS_W   = $clog2(Q_SCALE + 1);
  // quotient holds either an average (< 2**RAW_W) or a current (<= Q_SCALE)
  localparam int QUO_W  = (QS_W > RAW_W) ? QS_W : RAW_W;
  localparam int NUM_W  = RAW_W + QUO_W;
  localparam int SUMC_W = CUR_W + 1;

  localparam logic [CNT_W-1:0]         CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
  localparam logic [NUM_W-1:0]         Q_MULT   = NUM_W'(Q_SCALE);
  localparam logic [RAW_W-1:0]         CAL_DIV  = RAW_W'(CAL_SAMPLES);
  localparam logic signed [SUMC_W-1:0] Q_POS    = SUMC_W'(Q_SCALE);
  localparam logic signed [SUMC_W-1:0] Q_NEG    = -Q_POS;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  logic [1:0]        ch_q, ch_d;          // phase being worked on
  logic              avg_mode_q, avg_mode_d;  // dividing sums, not scaling
  logic              sign_q, sign_d;      // sample below its base
  logic [TOPO_W-1:0] topology_q;
  logic              calibrating_q, calibrating_d;
  logic              valid_q, valid_d;    // offsets calibrated
  logic [CNT_W-1:0]  count_q, count_d;

  logic [SUM_W-1:0]        sum_q    [3];
  logic [SUM_W-1:0]        sum_d    [3];
  logic [RAW_W-1:0]        offset_q [3];
  logic [RAW_W-1:0]        offset_d [3];
  logic [RAW_W-1:0]        raw_q    [3];
  logic [RAW_W-1:0]        raw_d    [3];
  logic signed [CUR_W-1:0] cur_q    [3];
  logic signed [CUR_W-1:0] cur_d    [3];

  logic                    out_valid_q, out_valid_d;
  logic signed [CUR_W-1:0] out_u_q, out_v_q, out_w_q;
  logic                    out_cal_q, out_incal_q;
  logic                    out_load;

  // ---------------------------------------------------------------------
  // Per-phase datapath: base select, clamp, scale multiply
  // ---------------------------------------------------------------------
  logic [RAW_W-1:0] raw_sel, offset_sel, base_sel;
  logic [SUM_W-1:0] sum_sel;
  logic [RAW_W-1:0] diff_neg, diff_pos, mag;
  logic             below;
  logic [NUM_W-1:0] prod;

  always_comb begin
    case (ch_q)
      2'd0:    begin raw_sel = raw_q[0]; offset_sel = offset_q[0]; sum_sel = sum_q[0]; end
      2'd1:    begin raw_sel = raw_q[1]; offset_sel = offset_q[1]; sum_sel = sum_q[1]; end
      default: begin raw_sel = raw_q[2]; offset_sel = offset_q[2]; sum_sel = sum_q[2]; end
    endcase
  end

  assign base_sel = valid_q ? offset_sel : MID_CODE;
  assign below    = (raw_sel < base_sel);
  assign diff_neg = base_sel - raw_sel;
  assign diff_pos = raw_sel - base_sel;
  // negative side never exceeds the base; only the positive side clamps
  assign mag      = below ? diff_neg : ((diff_pos > base_sel) ? base_sel : diff_pos);
  assign prod     = {{(NUM_W-RAW_W){1'b0}}, mag} * Q_MULT;

  // ---------------------------------------------------------------------
  // Shared divider
  // ---------------------------------------------------------------------
  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [RAW_W-1:0] div_divisor;
  logic [QUO_W-1:0] div_quo;

  assign div_dividend = avg_mode_q ? NUM_W'(sum_sel) : prod;
  assign div_divisor  = avg_mode_q ? CAL_DIV : base_sel;

  pcor_div #(
    .DIVD_W (NUM_W),
    .QUO_W  (QUO_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // quotient post-processing
  logic [RAW_W-1:0]        avg_fixed;
  logic signed [CUR_W-1:0] q_signed;
  logic                    last_ch;

  assign avg_fixed = (div_quo < QUO_W'(MIN_OFFSET)) ? MID_CODE : div_quo[RAW_W-1:0];
  assign q_signed  = sign_q ? -CUR_W'(div_quo) : CUR_W'(div_quo);
  assign last_ch   = (avg_mode_q || topology_q == TOPO_THREE) ? (ch_q == 2'd2)
                                                              : (ch_q == 2'd1);

  // derived W phase for two shunts, saturated
  logic signed [SUMC_W-1:0] uv_sum, w_neg, w_sat;

  assign uv_sum = SUMC_W'(cur_q[0]) + SUMC_W'(cur_q[1]);
  assign w_neg  = -uv_sum;
  assign w_sat  = (w_neg > Q_POS) ? Q_POS : ((w_neg < Q_NEG) ? Q_NEG : w_neg);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    ch_d          = ch_q;
    avg_mode_d    = avg_mode_q;
    sign_d        = sign_q;
    calibrating_d = calibrating_q;
    valid_d       = valid_q;
    count_d       = count_q;
    sum_d         = sum_q;
    offset_d      = offset_q;
    raw_d         = raw_q;
    cur_d         = cur_q;
    div_start     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ch_d  = 2'd0;
          cur_d = '{default: '0};
          if (kind_i == KIND_START) begin
            calibrating_d = 1'b1;
            valid_d       = 1'b0;
            count_d       = '0;
            sum_d         = '{default: '0};
          end else if (calibrating_q) begin
            sum_d[0] = sum_q[0] + SUM_W'(raw_u_i);
            sum_d[1] = sum_q[1] + SUM_W'(raw_v_i);
            sum_d[2] = sum_q[2] + SUM_W'(raw_w_i);
            if (count_q == CNT_LAST) begin
              count_d    = '0;
              avg_mode_d = 1'b1;
              state_d    = S_MUL;
            end else begin
              count_d = count_q + 1'b1;
              state_d = S_OUT;
            end
          end else begin
            raw_d      = '{raw_u_i, raw_v_i, raw_w_i};
            avg_mode_d = 1'b0;
            state_d    = (topology_q == TOPO_THREE || topology_q == TOPO_TWO) ? S_MUL : S_OUT;
          end
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        sign_d    = !avg_mode_q && below;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (avg_mode_q) begin
            offset_d[ch_q] = avg_fixed;
          end else begin
            cur_d[ch_q] = q_signed;
          end
          if (!last_ch) begin
            ch_d    = ch_q + 1'b1;
            state_d = S_MUL;
          end else if (avg_mode_q) begin
            valid_d       = 1'b1;
            calibrating_d = 1'b0;
            state_d       = S_OUT;
          end else if (topology_q == TOPO_TWO) begin
            state_d = S_W;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_W: begin
        cur_d[2] = CUR_W'(w_sat);
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ch_q          <= '0;
      avg_mode_q    <= 1'b0;
      topology_q    <= TOPO_THREE;
      calibrating_q <= 1'b0;
      valid_q       <= 1'b0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      ch_q          <= ch_d;
      avg_mode_q    <= avg_mode_d;
      calibrating_q <= calibrating_d;
      valid_q       <= valid_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        topology_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset; offsets are only read once marked valid
  always_ff @(posedge clk_i) begin
    sign_q   <= sign_d;
    sum_q    <= sum_d;
    offset_q <= offset_d;
    raw_q    <= raw_d;
    cur_q    <= cur_d;
    if (out_load) begin
      out_u_q     <= cur_q[0];
      out_v_q     <= cur_q[1];
      out_w_q     <= cur_q[2];
      out_cal_q   <= valid_q;
      out_incal_q <= calibrating_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign current_u_o      = out_u_q;
  assign current_v_o      = out_v_q;
  assign current_w_o      = out_w_q;
  assign is_calibrated_o  = out_cal_q;
  assign in_calibration_o = out_incal_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cal_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(calibrating_q && valid_q))
    else $error("calibrating while offsets marked valid");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i == KIND_START) |=> (calibrating_q && !valid_q && count_q == '0))
    else $error("start transaction did not restart calibration");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_LAST)
    else $error("sample count beyond calibration length");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while accepting input");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

// ===== dv/phase_current_offset_reconstruct_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the phase current offset calibration and reconstruction block.
module phase_current_offset_reconstruct_tb;
  import pcor_pkg::*;

  localparam int CAL_SAMPLES   = 512;
  localparam int Q_SCALE       = 32768;
  localparam int CYCLE_LIMIT   = 1_000_000;  // watchdog limit for the whole run
  localparam int SETTLE_CYCLES = 100;        // wait after the last result, beyond the longest reconstruction
  localparam int HOLD_CYCLES   = 400;        // one long output back-pressure window
  localparam int HOLD_AFTER    = 150;        // results seen before the window opens
  localparam int RANDOM_ITEMS  = 1450;
  localparam int MIN_PHASES    = 4;

  // topology codes that the package leaves unnamed
  localparam logic [TOPO_W-1:0] TOPO_SINGLE = 2'd2;
  localparam logic [TOPO_W-1:0] TOPO_UNUSED = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [RAW_W-1:0] u, v, w;
  } adc_item_t;

  typedef struct {
    logic signed [CUR_W-1:0] cu, cv, cw;
    logic                    cal_ok, cal_busy;
  } current_set_t;

  // DUT ports; every input starts at a known value
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    kind_i      = KIND_SAMPLE;
  logic [RAW_W-1:0]        raw_u_i     = '0;
  logic [RAW_W-1:0]        raw_v_i     = '0;
  logic [RAW_W-1:0]        raw_w_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [CUR_W-1:0] current_u_o, current_v_o, current_w_o;
  logic                    is_calibrated_o, in_calibration_o;
  logic                    cfg_we_i    = 1'b0;
  logic [TOPO_W-1:0]       cfg_wdata_i = TOPO_THREE;

  // Shadow of the block's state, kept by the predictor.
  logic [TOPO_W-1:0] topo_shadow = TOPO_THREE;
  logic [RAW_W-1:0]  ofs_u = MID_CODE, ofs_v = MID_CODE, ofs_w = MID_CODE;
  bit                ofs_valid  = 1'b0;
  bit                cal_active = 1'b0;
  int unsigned       cal_count = 0, acc_u = 0, acc_v = 0, acc_w = 0;

  // Stimulus queue, expected results and bookkeeping.
  adc_item_t    adc_q[$];
  current_set_t currents_due[$];
  int unsigned  cycle_count = 0;
  int unsigned  sets_sent = 0, results_seen = 0, mismatches = 0;
  int unsigned  cals_done = 0, offsets_replaced = 0;
  logic         in_taken = 1'b0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  phase_current_offset_reconstruct #(
    .CAL_SAMPLES(CAL_SAMPLES),
    .Q_SCALE    (Q_SCALE)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .raw_u_i         (raw_u_i),
    .raw_v_i         (raw_v_i),
    .raw_w_i         (raw_w_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .current_u_o     (current_u_o),
    .current_v_o     (current_v_o),
    .current_w_o     (current_w_o),
    .is_calibrated_o (is_calibrated_o),
    .in_calibration_o(in_calibration_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Offset-corrected sample: clamp the difference to +/-base, then scale to
  // +/-Q_SCALE with a wide product. Division truncates toward zero.
  function automatic longint phase_current(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] base);
    longint b, d;
    b = longint'(base);
    d = longint'(raw);
    d = d - b;
    if (b == 0) return 0;
    if (d > b) d = b;
    if (d < -b) d = -b;
    return (d * Q_SCALE) / b;
  endfunction

  function automatic longint clamp_q(longint x);
    if (x > Q_SCALE) return Q_SCALE;
    if (x < -Q_SCALE) return -Q_SCALE;
    return x;
  endfunction

  // Truncated average; an implausibly low one falls back to mid-scale.
  function automatic logic [RAW_W-1:0] averaged_offset(int unsigned acc);
    int unsigned avg;
    avg = acc / CAL_SAMPLES;
    if (avg < MIN_OFFSET) begin
      offsets_replaced++;
      return MID_CODE;
    end
    return avg[RAW_W-1:0];
  endfunction

  // Advances the shadow state by one transaction. Returns 1 with the expected
  // currents when the transaction yields a result (start commands do not).
  function automatic bit reconstruct_currents(adc_item_t it, output current_set_t res);
    logic [RAW_W-1:0] bu, bv, bw;
    longint           iu, iv, iw;
    iu  = 0;
    iv  = 0;
    iw  = 0;
    res = '{default: '0};
    if (it.kind == KIND_START) begin
      // start (or restart) discards everything learned so far
      ofs_u      = MID_CODE;
      ofs_v      = MID_CODE;
      ofs_w      = MID_CODE;
      ofs_valid  = 1'b0;
      cal_count  = 0;
      acc_u      = 0;
      acc_v      = 0;
      acc_w      = 0;
      cal_active = 1'b1;
      return 1'b0;
    end
    if (cal_active) begin
      // accumulate; currents stay zero during calibration
      acc_u += it.u;
      acc_v += it.v;
      acc_w += it.w;
      cal_count++;
      if (cal_count >= CAL_SAMPLES) begin
        ofs_u      = averaged_offset(acc_u);
        ofs_v      = averaged_offset(acc_v);
        ofs_w      = averaged_offset(acc_w);
        ofs_valid  = 1'b1;
        cal_active = 1'b0;
        cals_done++;
      end
    end else begin
      bu = ofs_valid ? ofs_u : MID_CODE;
      bv = ofs_valid ? ofs_v : MID_CODE;
      bw = ofs_valid ? ofs_w : MID_CODE;
      if (topo_shadow == TOPO_THREE) begin
        iu = phase_current(it.u, bu);
        iv = phase_current(it.v, bv);
        iw = phase_current(it.w, bw);
      end else if (topo_shadow == TOPO_TWO) begin
        // raw_w is ignored; w comes from Kirchhoff, saturated
        iu = phase_current(it.u, bu);
        iv = phase_current(it.v, bv);
        iw = clamp_q(-(iu + iv));
      end
      // single shunt and the spare code leave all currents at zero
    end
    res.cu       = iu[CUR_W-1:0];
    res.cv       = iv[CUR_W-1:0];
    res.cw       = iw[CUR_W-1:0];
    res.cal_ok   = ofs_valid;
    res.cal_busy = cal_active;
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic signed [CUR_W-1:0] want,
                             logic signed [CUR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // About 20% idle cycles per side, except in a recurring quiet window
  // where both sides run flat out.
  function automatic bit take_gap();
    if ((cycle_count / 4096) % 8 == 3) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle count and watchdog
  // ---------------------------------------------------------------------------
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog_p
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. Results are checked
  // against the oldest expectation; accepted input transactions feed the
  // predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_p
    adc_item_t    seen;
    current_set_t due;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (currents_due.size() == 0) begin
          $error("result with no transaction pending: current_u %0d", current_u_o);
          mismatches++;
        end else begin
          due = currents_due.pop_front();
          check_field("current_u", due.cu, current_u_o);
          check_field("current_v", due.cv, current_v_o);
          check_field("current_w", due.cw, current_w_o);
          check_field("is_calibrated", CUR_W'(due.cal_ok), CUR_W'(is_calibrated_o));
          check_field("in_calibration", CUR_W'(due.cal_busy), CUR_W'(in_calibration_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        sets_sent++;
        seen = '{kind_i, raw_u_i, raw_v_i, raw_w_i};
        if (reconstruct_currents(seen, due)) currents_due.push_back(due);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: at the falling edge, once the current transaction has been taken
  // (or none is up), either idles or presents the next queued item. Valid and
  // payload hold until the block accepts them.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed_p
    adc_item_t it;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (adc_q.size() != 0 && !take_gap()) begin
        it = adc_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= it.kind;
        raw_u_i    <= it.u;
        raw_v_i    <= it.v;
        raw_w_i    <= it.w;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result-side ready. Once, after HOLD_AFTER results, ready is held low over
  // the back-pressure window while the driver keeps offering: the output register
  // fills, the next transaction finishes behind it, and in_ready_o must stay low.
  always @(negedge clk_i) begin : accept_p
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && !take_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(logic kind, logic [RAW_W-1:0] u, logic [RAW_W-1:0] v,
                          logic [RAW_W-1:0] w);
    adc_q.push_back('{kind, u, v, w});
  endtask

  // level +/- 256 LSB of noise, kept in ADC range
  function automatic logic [RAW_W-1:0] jittered(int unsigned level);
    int s;
    s = int'(level) + int'($urandom_range(512)) - 256;
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return s[RAW_W-1:0];
  endfunction

  // DC level for a calibration run; covers the low-offset fallback, the
  // clamp region (base below mid-scale), mid-scale, high offsets and the
  // neighborhood of the fallback threshold.
  function automatic int unsigned cal_level();
    case ($urandom_range(4))
      0:       return $urandom_range(7000);
      1:       return $urandom_range(20000, 8200);
      2:       return $urandom_range(35000, 30000);
      3:       return $urandom_range(65535, 45000);
      default: return $urandom_range(8300, 7700);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] adc_sample();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return jittered(32'(MID_CODE));
      default: return RAW_W'($urandom_range(65535));
    endcase
  endfunction

  // start command followed by n noisy samples around the given levels
  task automatic add_calibration(int unsigned lu, int unsigned lv, int unsigned lw, int n);
    add_item(KIND_START, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
    repeat (n) add_item(KIND_SAMPLE, jittered(lu), jittered(lv), jittered(lw));
  endtask

  // Everything sent and answered; then extra cycles in case the last
  // transaction was a start command, which produces no result.
  task automatic wait_idle();
    while (adc_q.size() != 0 || in_valid_i || currents_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_topology(logic [TOPO_W-1:0] t);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = t;
    topo_shadow = t;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus_p
    logic [TOPO_W-1:0] topo;
    int unsigned       phase, plan, made, lu, lv, lw, k, n;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, uncalibrated: every base is mid-scale.
    // Three shunts: full-scale both ways and the codes around mid-scale.
    add_item(KIND_SAMPLE, '0, '1, MID_CODE);
    add_item(KIND_SAMPLE, '1, '0, MID_CODE - 1);
    add_item(KIND_SAMPLE, MID_CODE + 1, 16'h5555, 16'hAAAA);
    wait_idle();
    // Two shunts: derived w saturating in both directions, raw_w ignored.
    write_topology(TOPO_TWO);
    add_item(KIND_SAMPLE, '1, '1, '0);
    add_item(KIND_SAMPLE, '0, '0, '1);
    add_item(KIND_SAMPLE, 16'h9000, 16'h7000, 16'h1234);
    wait_idle();
    // Single shunt and the spare code: zero currents.
    write_topology(TOPO_SINGLE);
    add_item(KIND_SAMPLE, '1, '0, 16'h8001);
    wait_idle();
    write_topology(TOPO_UNUSED);
    add_item(KIND_SAMPLE, '0, '1, 16'h7FFF);
    wait_idle();
    // Start, partial accumulation, then a restart in mid-calibration.
    write_topology(TOPO_THREE);
    add_item(KIND_START, '1, '1, '1);
    add_item(KIND_SAMPLE, '1, '0, 16'h8000);
    add_item(KIND_SAMPLE, '0, '1, 16'h7FFF);
    add_item(KIND_START, '0, '0, '0);
    add_item(KIND_SAMPLE, 16'h4000, 16'hC000, MID_CODE);
    wait_idle();

    // Random phases. Each sets a topology, now and then runs a complete
    // calibration (sometimes after an abandoned one), then streams sample
    // sets with an occasional stray start command.
    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS || phase < MIN_PHASES) begin
      case (phase)
        0:       topo = TOPO_TWO;
        1:       topo = TOPO_THREE;
        2:       topo = TOPO_SINGLE;
        3:       topo = TOPO_UNUSED;
        default: topo = ($urandom_range(3) == 0) ? TOPO_W'($urandom_range(3))
                                                 : TOPO_W'($urandom_range(1));
      endcase
      write_topology(topo);

      plan = (phase == 0) ? 0 : $urandom_range(7);
      if (plan == 1) begin
        // abandoned run, restarted from scratch below
        k = $urandom_range(CAL_SAMPLES - 1, 1);
        add_calibration(cal_level(), cal_level(), cal_level(), k);
        made += k + 1;
      end
      if (plan <= 1) begin
        if (phase == 0) begin
          // first run: one phase falls back, one clamps, one sits high
          lu = $urandom_range(7000);
          lv = $urandom_range(20000, 8200);
          lw = $urandom_range(65535, 45000);
        end else begin
          lu = cal_level();
          lv = cal_level();
          lw = cal_level();
        end
        add_calibration(lu, lv, lw, CAL_SAMPLES);
        made += CAL_SAMPLES + 1;
      end

      n = $urandom_range(200, 100);
      repeat (n) begin
        if ($urandom_range(199) == 0) begin
          add_item(KIND_START, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
        end else begin
          add_item(KIND_SAMPLE, adc_sample(), adc_sample(), adc_sample());
        end
      end
      made += n;
      wait_idle();
      phase++;
    end

    $display("summary: %0d transactions sent over %0d random phases, %0d results checked",
             sets_sent, phase, results_seen);
    $display("summary: %0d calibrations completed, %0d offsets fell back to mid-scale",
             cals_done, offsets_replaced);
    if (mismatches == 0 && currents_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
